@@ design/dfmt_pkg.sv @@
package dfmt_pkg;

    localparam int DEF_MAX_FIELD_WIDTH = 63;
    localparam int VALUE_W = 64;
    localparam int NUM_DIGITS = 20;
    localparam int DIG_IDX_W = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W = $clog2(VALUE_W + 1);
    localparam int WIDE_W = 7;

    localparam logic [1:0] SIZE_SHORT = 2'd0;
    localparam logic [1:0] SIZE_INT = 2'd1;

    localparam logic [1:0] SIGN_PLUS = 2'd1;
    localparam logic [1:0] SIGN_SPACE = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [1:0] SEL_SPACE = 2'd0;
    localparam logic [1:0] SEL_PREFIX = 2'd1;
    localparam logic [1:0] SEL_DIGIT = 2'd2;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        is_signed;
        logic [1:0]  size_mode;
        logic [5:0]  pad_width;
        logic        left_justify;
        logic [1:0]  sign_flag;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic       load;
        logic       conv_step;
        logic       prep;
        logic       emit;
        logic [1:0] sel;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic pad_calc_zero;
        logic pad_zero;
        logic pad_one;
        logic dig_zero;
        logic has_prefix;
        logic left;
        logic out_free;
    } dp_sts_t;

endpackage

@@ design/decimal_field_formatter.sv @@
// Each item's 16, 32 or 64 bits (short, int, long) pass through the
// one-bit-per-cycle binary to decimal converter, then the field is sized,
// then one character per cycle into the output register while it is not stalled.
// A new item is taken only once the final character of the last one is written.
// Reset: rst_n clears the controller and the output valid flag at once.
module decimal_field_formatter
    import dfmt_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    dfmt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    dfmt_dp #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // A new item starts the converter, so the input closes on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input still open after an item was accepted");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv_step, cmd.prep, cmd.emit}))
        else $error("more than one datapath command at once");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("character written over a result still waiting");

    a_last_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> !item_stall)
        else $error("final character written but the input stays closed");

endmodule

@@ design/dfmt_ctrl.sv @@
module dfmt_ctrl
    import dfmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_PAD_PRE = 3'd3;
    localparam logic [2:0] ST_PREFIX = 3'd4;
    localparam logic [2:0] ST_DIGITS = 3'd5;
    localparam logic [2:0] ST_PAD_POST = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        cmd.sel = SEL_SPACE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (sts.conv_last)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (!sts.left && !sts.pad_calc_zero)
                begin
                    state_next = ST_PAD_PRE;
                end
                else if (sts.has_prefix)
                begin
                    state_next = ST_PREFIX;
                end
                else
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_PAD_PRE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel = SEL_SPACE;
                    if (sts.pad_one)
                    begin
                        state_next = sts.has_prefix ? ST_PREFIX : ST_DIGITS;
                    end
                end
            end
            ST_PREFIX:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel = SEL_PREFIX;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel = SEL_DIGIT;
                    cmd.last = sts.dig_zero && (!sts.left || sts.pad_zero);
                    if (sts.dig_zero)
                    begin
                        state_next = (sts.left && !sts.pad_zero) ? ST_PAD_POST : ST_IDLE;
                    end
                end
            end
            ST_PAD_POST:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel = SEL_SPACE;
                    cmd.last = sts.pad_one;
                    if (sts.pad_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/dfmt_dp.sv @@
module dfmt_dp
    import dfmt_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = DEF_MAX_FIELD_WIDTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  dp_cmd_t   cmd,
    output dp_sts_t   sts,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int PAD_W = $clog2(MAX_FIELD_WIDTH + 1);

    logic [VALUE_W-1:0]          bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][3:0]  bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [7:0]                  prefix_reg, prefix_next;
    logic                        has_prefix_reg, has_prefix_next;
    logic                        left_reg, left_next;
    logic [PAD_W-1:0]            width_reg, width_next;
    logic [PAD_W-1:0]            pad_cnt_reg, pad_cnt_next;
    logic [DIG_IDX_W-1:0]        dig_idx_reg, dig_idx_next;
    out_item_t                   out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    logic [VALUE_W-1:0]         mask;
    logic [VALUE_W-1:0]         masked;
    logic [VALUE_W-1:0]         mag;
    logic                       neg;
    logic [NUM_DIGITS-1:0][3:0] bcd_adj;
    logic [DIG_IDX_W:0]         num_digits;
    logic [WIDE_W-1:0]          text_len;
    logic [WIDE_W-1:0]          width_ext;
    logic [WIDE_W-1:0]          width_clamp;
    logic [WIDE_W-1:0]          pad_calc;
    logic [7:0]                 emit_char;

    // Magnitude of the argument after cutting it to its size.
    always_comb
    begin
        case (item.size_mode)
            SIZE_SHORT: mask = {{(VALUE_W - 16){1'b0}}, {16{1'b1}}};
            SIZE_INT:   mask = {{(VALUE_W - 32){1'b0}}, {32{1'b1}}};
            default:    mask = {VALUE_W{1'b1}};
        endcase
        masked = item.value_bits & mask;
        case (item.size_mode)
            SIZE_SHORT: neg = item.is_signed && masked[15];
            SIZE_INT:   neg = item.is_signed && masked[31];
            default:    neg = item.is_signed && masked[VALUE_W-1];
        endcase
        mag = (neg ? (~masked + 1'b1) : masked) & mask;
    end

    // One double-dabble step: bump digits of five or more, then shift a bit in.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    always_comb
    begin
        num_digits = (DIG_IDX_W + 1)'(1);
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                num_digits = (DIG_IDX_W + 1)'(i + 1);
            end
        end
        text_len = WIDE_W'(num_digits) + WIDE_W'(has_prefix_reg);
        pad_calc = (WIDE_W'(width_reg) > text_len) ? (WIDE_W'(width_reg) - text_len)
                                                   : '0;
        width_ext = WIDE_W'(item.pad_width);
        width_clamp = (width_ext > WIDE_W'(MAX_FIELD_WIDTH)) ? WIDE_W'(MAX_FIELD_WIDTH)
                                                             : width_ext;
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_PREFIX: emit_char = prefix_reg;
            SEL_DIGIT:  emit_char = CHAR_ZERO | {4'd0, bcd_reg[dig_idx_reg]};
            default:    emit_char = CHAR_SPACE;
        endcase
    end

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        prefix_next = prefix_reg;
        has_prefix_next = has_prefix_reg;
        left_next = left_reg;
        width_next = width_reg;
        pad_cnt_next = pad_cnt_reg;
        dig_idx_next = dig_idx_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        if (cmd.load)
        begin
            bcd_next = '0;
            left_next = item.left_justify;
            width_next = PAD_W'(width_clamp);
            // The value is left-aligned so that only its own bits are shifted in.
            case (item.size_mode)
                SIZE_SHORT:
                begin
                    bin_next = mag << (VALUE_W - 16);
                    bit_cnt_next = BIT_CNT_W'(16);
                end
                SIZE_INT:
                begin
                    bin_next = mag << (VALUE_W - 32);
                    bit_cnt_next = BIT_CNT_W'(32);
                end
                default:
                begin
                    bin_next = mag;
                    bit_cnt_next = BIT_CNT_W'(VALUE_W);
                end
            endcase
            has_prefix_next = 1'b1;
            if (neg)
            begin
                prefix_next = CHAR_MINUS;
            end
            else if (item.is_signed && item.sign_flag == SIGN_PLUS)
            begin
                prefix_next = CHAR_PLUS;
            end
            else if (item.is_signed && item.sign_flag == SIGN_SPACE)
            begin
                prefix_next = CHAR_SPACE;
            end
            else
            begin
                prefix_next = CHAR_SPACE;
                has_prefix_next = 1'b0;
            end
        end

        if (cmd.conv_step)
        begin
            // The top digit never exceeds two, so its high bit drops out of the shift.
            bcd_next = {bcd_adj[NUM_DIGITS-1][2:0], bcd_adj[NUM_DIGITS-2:0],
                        bin_reg[VALUE_W-1]};
            bin_next = bin_reg << 1;
            bit_cnt_next = bit_cnt_reg - 1'b1;
        end

        if (cmd.prep)
        begin
            pad_cnt_next = PAD_W'(pad_calc);
            dig_idx_next = DIG_IDX_W'(num_digits - 1'b1);
        end

        if (cmd.emit)
        begin
            out_next.out_char = emit_char;
            out_next.out_last = cmd.last;
            out_valid_next = 1'b1;
            if (cmd.sel == SEL_SPACE)
            begin
                pad_cnt_next = pad_cnt_reg - 1'b1;
            end
            if (cmd.sel == SEL_DIGIT)
            begin
                dig_idx_next = dig_idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        prefix_reg <= prefix_next;
        has_prefix_reg <= has_prefix_next;
        left_reg <= left_next;
        width_reg <= width_next;
        pad_cnt_reg <= pad_cnt_next;
        dig_idx_reg <= dig_idx_next;
        out_reg <= out_next;
    end

    assign sts.conv_last = (bit_cnt_reg == BIT_CNT_W'(1));
    assign sts.pad_calc_zero = (pad_calc == '0);
    assign sts.pad_zero = (pad_cnt_reg == '0);
    assign sts.pad_one = (pad_cnt_reg == PAD_W'(1));
    assign sts.dig_zero = (dig_idx_reg == '0);
    assign sts.has_prefix = has_prefix_reg;
    assign sts.left = left_reg;
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result = out_reg;

endmodule

@@ tb/sv/tb_decimal_field_formatter.sv @@
module tb_decimal_field_formatter;
    import dfmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_LIMIT = DEF_MAX_FIELD_WIDTH;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_PER_PHASE = 25;

    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_ALT_LONG = 2'd3;
    localparam logic [1:0] SIGN_NONE = 2'd0;
    localparam logic [1:0] SIGN_ALT_NONE = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    out_item_t pending_chars[$];
    int        fields_sent = 0;
    int        chars_checked = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    decimal_field_formatter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected text of one field, queued one character per result.
    function automatic void format_field(input in_item_t it);
        logic [63:0] mag;
        logic        neg;
        logic        has_prefix;
        logic [7:0]  prefix;
        logic [7:0]  text[$];
        out_item_t   ch;
        int          field_w;
        int          pad;
        neg = 1'b0;
        has_prefix = 1'b0;
        prefix = CHAR_SPACE;
        case (it.size_mode)
            SIZE_SHORT:
            begin
                mag = 64'(it.value_bits[15:0]);
                if (it.is_signed && mag[15])
                begin
                    neg = 1'b1;
                    mag = 64'h1_0000 - mag;
                end
            end
            SIZE_INT:
            begin
                mag = 64'(it.value_bits[31:0]);
                if (it.is_signed && mag[31])
                begin
                    neg = 1'b1;
                    mag = 64'h1_0000_0000 - mag;
                end
            end
            default:
            begin
                mag = it.value_bits;
                if (it.is_signed && mag[63])
                begin
                    neg = 1'b1;
                    mag = -mag;
                end
            end
        endcase
        do
        begin
            text.push_front(CHAR_ZERO + 8'(mag % 64'd10));
            mag = mag / 64'd10;
        end
        while (mag != 64'd0);
        // A sign flag only applies to a non-negative signed conversion.
        if (neg)
        begin
            has_prefix = 1'b1;
            prefix = CHAR_MINUS;
        end
        else if (it.is_signed && it.sign_flag == SIGN_PLUS)
        begin
            has_prefix = 1'b1;
            prefix = CHAR_PLUS;
        end
        else if (it.is_signed && it.sign_flag == SIGN_SPACE)
        begin
            has_prefix = 1'b1;
        end
        if (has_prefix)
            text.push_front(prefix);
        field_w = (it.pad_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(it.pad_width);
        pad = field_w - text.size();
        for (int i = 0; i < pad; i++)
        begin
            if (it.left_justify)
                text.push_back(CHAR_SPACE);
            else
                text.push_front(CHAR_SPACE);
        end
        foreach (text[i])
        begin
            ch.out_char = text[i];
            ch.out_last = (i == text.size() - 1);
            pending_chars.push_back(ch);
        end
    endfunction

    function automatic in_item_t make_item(input logic [63:0] v, input logic sgn,
                                           input logic [1:0] size, input int width,
                                           input logic left, input logic [1:0] sflag);
        in_item_t it;
        it.value_bits = v;
        it.is_signed = sgn;
        it.size_mode = size;
        it.pad_width = 6'(width);
        it.left_justify = left;
        it.sign_flag = sflag;
        return it;
    endfunction

    // Called right after the previous acceptance; valid stays high across
    // back-to-back items and drops only for an idle gap.
    task automatic send_item(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        format_field(it);
        fields_sent++;
    endtask

    task automatic release_sender();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_extreme_values();
        send_item(make_item(64'd0, 1'b1, SIZE_SHORT, 0, 1'b0, SIGN_NONE));
        send_item(make_item(64'd0, 1'b0, SIZE_LONG, 63, 1'b0, SIGN_NONE));
        send_item(make_item(64'h0000_0000_0000_8000, 1'b1, SIZE_SHORT, 0, 1'b0, SIGN_NONE));
        send_item(make_item(64'h0000_0000_8000_0000, 1'b1, SIZE_INT, 12, 1'b0, SIGN_PLUS));
        send_item(make_item(64'h8000_0000_0000_0000, 1'b1, SIZE_LONG, 0, 1'b1, SIGN_NONE));
        send_item(make_item({64{1'b1}}, 1'b0, SIZE_LONG, 63, 1'b1, SIGN_NONE));
        send_item(make_item({64{1'b1}}, 1'b1, SIZE_LONG, 63, 1'b0, SIGN_SPACE));
        send_item(make_item(64'hDEAD_BEEF_CAFE_FFFF, 1'b0, SIZE_SHORT, 7, 1'b1, SIGN_NONE));
        send_item(make_item(64'h0000_0000_0000_7FFF, 1'b1, SIZE_SHORT, 6, 1'b0, SIGN_NONE));
        // The text is longer than the width, so no padding at all.
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, SIZE_LONG, 5, 1'b0, SIGN_PLUS));
        release_sender();
    endtask

    task automatic test_sign_flags();
        send_item(make_item(64'd42, 1'b1, SIZE_INT, 0, 1'b0, SIGN_NONE));
        send_item(make_item(64'd42, 1'b1, SIZE_INT, 0, 1'b0, SIGN_PLUS));
        send_item(make_item(64'd42, 1'b1, SIZE_INT, 4, 1'b1, SIGN_SPACE));
        send_item(make_item(64'd42, 1'b1, SIZE_INT, 0, 1'b0, SIGN_ALT_NONE));
        // A negative value gets its minus, never the plus.
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFD6, 1'b1, SIZE_INT, 0, 1'b0, SIGN_PLUS));
        send_item(make_item(64'd42, 1'b0, SIZE_INT, 0, 1'b0, SIGN_PLUS));
        send_item(make_item(64'd0, 1'b1, SIZE_SHORT, 0, 1'b0, SIGN_SPACE));
        release_sender();
    endtask

    task automatic test_size_selection();
        send_item(make_item(64'hFFFF_FFFF_FFFF_FF85, 1'b1, SIZE_ALT_LONG, 0, 1'b0, SIGN_NONE));
        send_item(make_item(64'h1234_5678_FFFF_FFFF, 1'b0, SIZE_INT, 0, 1'b0, SIGN_NONE));
        send_item(make_item(64'hABCD_0000_0000_04D2, 1'b1, SIZE_SHORT, 10, 1'b1, SIGN_PLUS));
        release_sender();
    endtask

    // The sender holds off until every character already owed has arrived.
    task automatic test_pause_until_drained();
        send_item(make_item(64'd98765, 1'b0, SIZE_INT, 20, 1'b0, SIGN_NONE));
        release_sender();
        wait_for_drain();
        send_item(make_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, SIZE_SHORT, 3, 1'b1, SIGN_NONE));
        release_sender();
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v[15:0] = 16'($urandom_range(999));
            1: v[15:0] = 16'h8000 ^ 16'($urandom_range(3));
            2: v[31:0] = 32'h8000_0000 ^ 32'($urandom_range(3));
            3: v = {1'b1, 63'($urandom_range(3))};
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_random_items(input int sender_idle, input int receiver_stall);
        in_item_t it;
        wait_for_drain();
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        for (int n = 0; n < RANDOM_PER_PHASE; n++)
        begin
            it.value_bits = pick_value();
            it.is_signed = 1'($urandom_range(1));
            it.size_mode = 2'($urandom_range(3));
            // Mostly short fields; now and then the full width range.
            it.pad_width = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(24));
            it.left_justify = 1'($urandom_range(1));
            it.sign_flag = 2'($urandom_range(3));
            send_item(it);
        end
        release_sender();
    endtask

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character 0x%02h last=%0b",
                         $time, result.out_char, result.out_last);
                error_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (result.out_char !== want.out_char)
                begin
                    $display("%0t: out_char expected 0x%02h, got 0x%02h",
                             $time, want.out_char, result.out_char);
                    error_count++;
                end
                if (result.out_last !== want.out_last)
                begin
                    $display("%0t: out_last expected %0b, got %0b",
                             $time, want.out_last, result.out_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, %0d characters still owed",
                     $time, QUIET_LIMIT, pending_chars.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extreme_values();
        test_sign_flags();
        test_size_selection();
        test_pause_until_drained();
        test_random_items(0, 0);
        test_random_items(63, 0);
        test_random_items(0, 63);
        test_random_items(35, 35);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Formatted %0d fields into %0d characters: all sizes and sign modes,",
                 fields_sent, chars_checked);
        $display("extreme values and widths, under four sender and receiver idle mixes.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
